[rtl/core/cpsp_pkg.sv]
`default_nettype none

package cpsp_pkg;

  localparam int unsigned SampleWidth  = 24;
  localparam int unsigned SineDepth    = 1024;
  localparam int unsigned GainWidth    = 16;
  localparam int unsigned RomAddrWidth = $clog2(SineDepth + 1);
  localparam int unsigned BalWidth     = 32;
  localparam int unsigned TargetWidth  = 16;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 1;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] Sqrt2Q30  = 64'd1518500250;

  // 0.05 in Q0.16.
  localparam logic [13:0] SmoothK = 14'd3277;

  localparam logic [GainWidth-1:0] GainUnity = 16'd16384;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTarget = 1'b0,
    CfgMono   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load_target;
    logic mult;
    logic add_step;
    logic latch_idx;
  } bal_ctrl_t;

  typedef logic [GainWidth-1:0] gain_rom_t [SineDepth+1];

  // Quarter sine scaled by sqrt(2), Q2.14. The sine is a Q30 Taylor series
  // through x^13 with truncation after each step.
  function automatic gain_rom_t build_gain_rom();
    gain_rom_t           rom;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic [63:0]         g;
    logic signed [63:0]  s;
    for (int k = 0; k <= SineDepth; k++) begin
      x    = (64'(k) * HalfPiQ30 + 64'(SineDepth / 2)) / SineDepth;
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      s    = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      s    = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      s    = s + $signed(term);
      if (s < 0) begin
        s = '0;
      end
      g      = ($unsigned(s) * Sqrt2Q30 + (64'd1 << 45)) >> 46;
      rom[k] = g[GainWidth-1:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cpsp_in_if.sv]
`default_nettype none

interface cpsp_in_if import cpsp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] left_in;
  logic signed [SampleWidth-1:0] right_in;
  logic                          block_start;
  logic                          jump_to_target;

  modport source (
    output valid, left_in, right_in, block_start, jump_to_target,
    input  ready
  );

  modport sink (
    input  valid, left_in, right_in, block_start, jump_to_target,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/cpsp_out_if.sv]
`default_nettype none

interface cpsp_out_if import cpsp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] left_out;
  logic signed [SampleWidth-1:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/constant_power_stereo_panner_top.sv]
`default_nettype none

// A plain pair runs only the apply and output states; a jump first runs the
// gain update from the index stage on, a block start all of it. A new pair is
// taken once the result is loaded for output. The gain update walks the
// balance multiplier, step add, index stage, two reads of the single-port gain
// ROM and left-gain capture, one state each. Reset (rst_ni, async, active low)
// centers the balance, sets unity gains, clears config and empties the output.
module constant_power_stereo_panner_top import cpsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  cpsp_in_if.sink                 in_if,
  cpsp_out_if.source              out_if,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned MulWidth = SampleWidth + GainWidth + 1;
  localparam int unsigned GainFrac = GainWidth - 2;

  localparam logic [RomAddrWidth-1:0] DepthAddr = RomAddrWidth'(SineDepth);

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SMult  = 9'b000000010,
    SStep  = 9'b000000100,
    SIndex = 9'b000001000,
    SRdR   = 9'b000010000,
    SRdL   = 9'b000100000,
    SGainL = 9'b001000000,
    SApply = 9'b010000000,
    SOut   = 9'b100000000
  } state_e;

  function automatic logic signed [SampleWidth-1:0] round_sat(
    input logic signed [MulWidth-1:0] p
  );
    logic signed [MulWidth-1:0] y;
    logic signed [MulWidth-1:0] hi;
    logic signed [MulWidth-1:0] lo;
    y  = (p + $signed(MulWidth'(1) << (GainFrac - 1))) >>> GainFrac;
    hi = $signed(MulWidth'({1'b0, {(SampleWidth - 1){1'b1}}}));
    lo = ~hi;
    if (y > hi) begin
      y = hi;
    end else if (y < lo) begin
      y = lo;
    end
    return y[SampleWidth-1:0];
  endfunction

  state_e state_q, state_d;

  logic signed [TargetWidth-1:0] target_q;
  logic                          mono_q;

  logic                          in_fire;
  logic                          out_fire;
  logic                          out_load;
  logic signed [SampleWidth:0]   pair_sum;
  logic signed [SampleWidth-1:0] l_q, r_q;
  logic                          bs_q;

  bal_ctrl_t                     bal_ctrl;
  logic [RomAddrWidth-1:0]       idx;
  logic [RomAddrWidth-1:0]       rom_addr;
  logic [GainWidth-1:0]          rom_data;
  logic [GainWidth-1:0]          gain_left_q, gain_right_q;

  logic signed [MulWidth-1:0]    prod_l_q, prod_r_q;
  logic                          out_valid_q;
  logic signed [SampleWidth-1:0] out_l_q, out_r_q;

  assign in_fire  = in_if.valid & in_if.ready;
  assign out_fire = out_if.valid & out_if.ready;
  assign out_load = (state_q == SOut) & (~out_valid_q | out_if.ready);

  assign in_if.ready = (state_q == SIdle);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      mono_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgTarget: target_q <= cfg_data_i[TargetWidth-1:0];
        CfgMono:   mono_q   <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          priority if (in_if.block_start) begin
            state_d = SMult;
          end else if (in_if.jump_to_target) begin
            state_d = SIndex;
          end else begin
            state_d = SApply;
          end
        end
      end
      SMult:  state_d = SStep;
      SStep:  state_d = SIndex;
      SIndex: state_d = SRdR;
      SRdR:   state_d = SRdL;
      SRdL:   state_d = SGainL;
      SGainL: state_d = SApply;
      SApply: state_d = SOut;
      SOut: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // The jump lands at the accepting edge so that smoothing sees the target.
  assign bal_ctrl.load_target = in_fire & in_if.jump_to_target;
  assign bal_ctrl.mult        = (state_q == SMult);
  assign bal_ctrl.add_step    = (state_q == SStep);
  assign bal_ctrl.latch_idx   = (state_q == SIndex);

  cpsp_balance u_balance (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (bal_ctrl),
    .target_i (target_q),
    .idx_o    (idx)
  );

  assign rom_addr = (state_q == SRdL) ? (DepthAddr - idx) : idx;

  cpsp_gain_rom u_gain_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_left_q  <= GainUnity;
      gain_right_q <= GainUnity;
    end else begin
      if (state_q == SRdL) begin
        gain_right_q <= rom_data;
      end
      if (state_q == SGainL) begin
        gain_left_q <= rom_data;
      end
    end
  end

  // Sample capture, with the mono average taken on the way in.
  assign pair_sum = {in_if.left_in[SampleWidth-1], in_if.left_in}
                  + {in_if.right_in[SampleWidth-1], in_if.right_in};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bs_q <= in_if.block_start;
      if (mono_q) begin
        l_q <= pair_sum[SampleWidth:1];
        r_q <= pair_sum[SampleWidth:1];
      end else begin
        l_q <= in_if.left_in;
        r_q <= in_if.right_in;
      end
    end
    if (state_q == SApply) begin
      prod_l_q <= MulWidth'(l_q) * MulWidth'($signed({1'b0, gain_left_q}));
      prod_r_q <= MulWidth'(r_q) * MulWidth'($signed({1'b0, gain_right_q}));
    end
    if (out_load) begin
      out_l_q <= round_sat(prod_l_q);
      out_r_q <= round_sat(prod_r_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.left_out  = out_l_q;
  assign out_if.right_out = out_r_q;

  a_accept_leaves_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != SIdle)
  ) else $error("accepted beat did not start processing");

  a_idx_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRdR) |-> (idx <= DepthAddr)
  ) else $error("gain ROM index beyond table depth");

  a_result_delivered : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q
  ) else $error("result not presented after load");

  a_gain_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == SApply) |-> ((gain_left_q <= 16'd23171) && (gain_right_q <= 16'd23171))
  ) else $error("gain above sqrt(2)");

  a_smooth_only_on_block : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMult) |-> bs_q
  ) else $error("smoothing without block start");

endmodule

`default_nettype wire

[rtl/core/cpsp_gain_rom.sv]
`default_nettype none

module cpsp_gain_rom import cpsp_pkg::*; (
  input  logic                    clk_i,
  input  logic [RomAddrWidth-1:0] addr_i,
  output logic [GainWidth-1:0]    data_o
);

  localparam gain_rom_t GainRom = build_gain_rom();

  logic [GainWidth-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= GainRom[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/core/cpsp_balance.sv]
`default_nettype none

module cpsp_balance import cpsp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bal_ctrl_t                     ctrl_i,
  input  logic signed [TargetWidth-1:0] target_i,
  output logic [RomAddrWidth-1:0]       idx_o
);

  localparam int unsigned FracShift = 15;
  localparam int unsigned ProdWidth = BalWidth + 1 + $bits(SmoothK) + 1;
  localparam int unsigned IdxProdW  = BalWidth + RomAddrWidth + 1;
  localparam int unsigned StepShift = 16;

  localparam logic signed [ProdWidth-1:0] StepRound = ProdWidth'(1) <<< (StepShift - 1);
  localparam logic signed [BalWidth:0]    PhaseOfs  = (BalWidth + 1)'(1) << (BalWidth - 2);
  localparam logic [BalWidth-1:0]         PhaseMax  = BalWidth'(1) << (BalWidth - 1);

  logic signed [BalWidth-1:0]   sb_q, sb_d;
  logic signed [BalWidth-1:0]   t30;
  logic signed [BalWidth:0]     diff;
  logic signed [ProdWidth-1:0]  prod_q;
  logic signed [ProdWidth-1:0]  step;
  logic signed [BalWidth:0]     phase;
  logic [BalWidth-1:0]          phase_clamped;
  logic [IdxProdW-1:0]          idx_prod;
  logic [RomAddrWidth-1:0]      idx_q;

  assign t30  = {{(BalWidth - TargetWidth - FracShift){target_i[TargetWidth-1]}},
                 target_i, {FracShift{1'b0}}};
  assign diff = {t30[BalWidth-1], t30} - {sb_q[BalWidth-1], sb_q};
  assign step = (prod_q + StepRound) >>> StepShift;

  always_comb begin
    sb_d = sb_q;
    priority if (ctrl_i.load_target) begin
      sb_d = t30;
    end else if (ctrl_i.add_step) begin
      sb_d = sb_q + step[BalWidth-1:0];
    end else begin
      sb_d = sb_q;
    end
  end

  // Pan phase: balance shifted to [0, 2^31], then scaled to the ROM depth.
  assign phase = {sb_q[BalWidth-1], sb_q} + PhaseOfs;

  always_comb begin
    priority if (phase[BalWidth]) begin
      phase_clamped = '0;
    end else if (phase[BalWidth-1:0] > PhaseMax) begin
      phase_clamped = PhaseMax;
    end else begin
      phase_clamped = phase[BalWidth-1:0];
    end
  end

  assign idx_prod = IdxProdW'(phase_clamped) * IdxProdW'(SineDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= '0;
    end else begin
      sb_q <= sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mult) begin
      prod_q <= ProdWidth'(diff) * ProdWidth'($signed({1'b0, SmoothK}));
    end
    if (ctrl_i.latch_idx) begin
      idx_q <= idx_prod[BalWidth-1 +: RomAddrWidth];
    end
  end

  assign idx_o = idx_q;

endmodule

`default_nettype wire
